// ===== hw/rtl/xmc_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xmc_pkg
// Shared types, constants and the XTEA round function of the XTEA MAC/CTR
// engine.
// ---------------------------------------------------------------------------
package xmc_pkg;

    localparam int unsigned NUM_ROUNDS    = 32;
    localparam int unsigned ROUND_W       = $clog2(NUM_ROUNDS);
    localparam logic [31:0] ROUND_DELTA   = 32'h9E3779B9;
    localparam int unsigned MIC_BYTES_DEF = 4;
    localparam int unsigned QUEUE_DEPTH   = 2;
    localparam int unsigned CFG_IDX_W     = 1;

    typedef enum logic [1:0] {
        OP_ENCRYPT = 2'd0,
        OP_MAC     = 2'd1,
        OP_CTR     = 2'd2,
        OP_RSVD    = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_UPPER = 1'b0,
        CFG_KEY_LOWER = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [63:0] upper;
        logic [63:0] lower;
    } key_t;

    // classified command between front and back
    typedef struct packed {
        op_t         op;
        logic [63:0] data;
        logic [63:0] mask;
        logic        first;
        logic        last;
        logic [63:0] cstart;
        logic [31:0] exp_mic;
    } cmd_t;

    function automatic logic [31:0] key_word(key_t k, logic [1:0] sel);
        logic [31:0] w;
        case (sel)
            2'd0:    w = k.upper[63:32];
            2'd1:    w = k.upper[31:0];
            2'd2:    w = k.lower[63:32];
            default: w = k.lower[31:0];
        endcase
        return w;
    endfunction

    function automatic logic [31:0] xtea_mix(logic [31:0] v);
        return ((v << 4) ^ (v >> 5)) + v;
    endfunction

    // one full round: both half rounds
    function automatic logic [63:0] xtea_round(logic [63:0] ab, logic [31:0] s, key_t k);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] s1;
        a  = ab[63:32] + (xtea_mix(ab[31:0]) ^ (s + key_word(k, s[1:0])));
        s1 = s + ROUND_DELTA;
        b  = ab[31:0] + (xtea_mix(a) ^ (s1 + key_word(k, s1[12:11])));
        return {a, b};
    endfunction

endpackage

// ===== hw/rtl/xtea_mac_ctr_engine.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xtea_mac_ctr_engine
// 32-round XTEA block engine: plain encrypt, CBC-MAC step with MIC check,
// counter mode step.
// ---------------------------------------------------------------------------
//  channel  | handshake          | payload
//  s_*      | s_valid / s_ready  | opcode, block_data, valid_bytes, first, last,
//           |                    | counter_start, expected_mic
//  m_*      | m_valid / m_ready  | result_data, mic_match
//  cfg_*    | cfg_valid/cfg_ready| cfg_index, cfg_data (key words)
//
//  One XTEA round per cycle: a block runs all rounds in the round engine, then
//  a hand-off state loads the result register and may take the next block;
//  reserved opcode beats skip the rounds and go straight to the hand-off.
//  A two-entry command queue before the round engine keeps s_ready high while
//  a block runs, until full; the result register lets rounds run with m_ready low.
//  Reset (aresetn, synchronous) clears keys, MAC chain, counter and queue.
//  m_ready low holds the result; the engine then waits with its next block.
// ---------------------------------------------------------------------------
module xtea_mac_ctr_engine #(
    parameter int unsigned MIC_BYTES = xmc_pkg::MIC_BYTES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [xmc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [63:0]                    cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_opcode,
    input  logic [63:0]                    s_block_data,
    input  logic [3:0]                     s_valid_bytes,
    input  logic                           s_first,
    input  logic                           s_last,
    input  logic [63:0]                    s_counter_start,
    input  logic [31:0]                    s_expected_mic,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [63:0]                    m_result_data,
    output logic                           m_mic_match
);

    xmc_pkg::key_t key_reg;
    logic          cmd_valid;
    logic          cmd_ready;
    xmc_pkg::cmd_t cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (xmc_pkg::cfg_idx_t'(cfg_index))
                xmc_pkg::CFG_KEY_UPPER: key_reg.upper <= cfg_data;
                xmc_pkg::CFG_KEY_LOWER: key_reg.lower <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    xmc_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_block_data    (s_block_data),
        .s_valid_bytes   (s_valid_bytes),
        .s_first         (s_first),
        .s_last          (s_last),
        .s_counter_start (s_counter_start),
        .s_expected_mic  (s_expected_mic),
        .cmd_valid       (cmd_valid),
        .cmd_ready       (cmd_ready),
        .cmd             (cmd)
    );

    xmc_back #(
        .MIC_BYTES (MIC_BYTES)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .key           (key_reg),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_data (m_result_data),
        .m_mic_match   (m_mic_match)
    );

endmodule

// ===== hw/rtl/xmc_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xmc_front
// Input beat acceptance, opcode classification, byte mask build and a short
// command queue toward the round engine.
// ---------------------------------------------------------------------------
module xmc_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_opcode,
    input  logic [63:0]         s_block_data,
    input  logic [3:0]          s_valid_bytes,
    input  logic                s_first,
    input  logic                s_last,
    input  logic [63:0]         s_counter_start,
    input  logic [31:0]         s_expected_mic,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output xmc_pkg::cmd_t       cmd
);

    localparam int unsigned PTR_W = $clog2(xmc_pkg::QUEUE_DEPTH);

    xmc_pkg::cmd_t     q_reg [xmc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W:0]    count_reg;
    logic [PTR_W:0]    count_next;
    xmc_pkg::cmd_t     in_cmd;
    logic [63:0]       mask;
    logic              push;
    logic              pop;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            mask[63-8*i -: 8] = {8{s_valid_bytes > 4'(i)}};
        end
    end

    always_comb begin
        in_cmd         = '0;
        in_cmd.op      = xmc_pkg::op_t'(s_opcode);
        in_cmd.mask    = mask;
        in_cmd.first   = s_first;
        in_cmd.last    = s_last;
        in_cmd.cstart  = s_counter_start;
        in_cmd.exp_mic = s_expected_mic;
        case (in_cmd.op)
            xmc_pkg::OP_ENCRYPT: in_cmd.data = s_block_data;
            default:             in_cmd.data = s_block_data & mask;
        endcase
    end

    assign s_ready   = (count_reg != (PTR_W+1)'(xmc_pkg::QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (PTR_W+1)'(xmc_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");
    a_ptr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0 || count_reg == (PTR_W+1)'(xmc_pkg::QUEUE_DEPTH))
        |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with count");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == (PTR_W+1)'(xmc_pkg::QUEUE_DEPTH) && !pop) |=> $stable(wr_ptr_reg))
        else $error("write into full queue");
`endif

endmodule

// ===== hw/rtl/xmc_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xmc_back
// Iterative XTEA round engine with MAC chain, counter block and result
// register.
// ---------------------------------------------------------------------------
module xmc_back #(
    parameter int unsigned MIC_BYTES = xmc_pkg::MIC_BYTES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  xmc_pkg::key_t       key,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  xmc_pkg::cmd_t       cmd,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [63:0]         m_result_data,
    output logic                m_mic_match
);

    localparam int unsigned MIC_SHIFT = 64 - 8 * MIC_BYTES;
    localparam logic [xmc_pkg::ROUND_W-1:0] LAST_ROUND =
        (xmc_pkg::ROUND_W)'(xmc_pkg::NUM_ROUNDS - 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                       state_reg, state_next;
    logic [xmc_pkg::ROUND_W-1:0]  cnt_reg, cnt_next;
    logic [63:0]                  ab_reg, ab_next;
    logic [31:0]                  sum_reg, sum_next;
    xmc_pkg::op_t                 op_reg;
    logic [63:0]                  data_reg;
    logic [63:0]                  mask_reg;
    logic                         last_reg;
    logic [31:0]                  exp_reg;
    logic [63:0]                  chain_reg, chain_next;
    logic [63:0]                  ctr_reg, ctr_next;
    logic                         m_valid_reg, m_valid_next;
    logic [63:0]                  m_data_reg, m_data_next;
    logic                         m_match_reg, m_match_next;

    logic        out_free;
    logic        start;
    logic [63:0] src_blk;
    logic [63:0] ctr_base;
    logic [63:0] round_ab;
    logic [63:0] mic_word;
    logic [63:0] res_data;
    logic        res_match;

    assign out_free  = !m_valid_reg || m_ready;
    assign cmd_ready = (state_reg == ST_IDLE) || (state_reg == ST_DONE && out_free);
    assign start     = cmd_valid && cmd_ready;
    assign round_ab  = xmc_pkg::xtea_round(ab_reg, sum_reg, key);
    assign ctr_base  = cmd.first ? cmd.cstart : ctr_reg;
    assign mic_word  = ab_reg >> MIC_SHIFT;

    always_comb begin
        case (cmd.op)
            xmc_pkg::OP_ENCRYPT: src_blk = cmd.data;
            xmc_pkg::OP_MAC:     src_blk = (cmd.first ? 64'd0 : chain_reg) ^ cmd.data;
            xmc_pkg::OP_CTR:     src_blk = ctr_base;
            default:             src_blk = 64'd0;
        endcase
    end

    // ab_reg holds the cipher output while in DONE
    always_comb begin
        res_match = 1'b0;
        case (op_reg)
            xmc_pkg::OP_ENCRYPT: res_data = ab_reg;
            xmc_pkg::OP_MAC: begin
                res_data  = ab_reg;
                res_match = last_reg && (mic_word == {32'd0, exp_reg});
            end
            xmc_pkg::OP_CTR:     res_data = (data_reg ^ ab_reg) & mask_reg;
            default:             res_data = 64'd0;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        ab_next      = ab_reg;
        sum_next     = sum_reg;
        chain_next   = chain_reg;
        ctr_next     = ctr_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        m_match_next = m_match_reg;

        case (state_reg)
            ST_RUN: begin
                ab_next  = round_ab;
                sum_next = sum_reg + xmc_pkg::ROUND_DELTA;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_ROUND) begin
                    state_next = ST_DONE;
                    if (op_reg == xmc_pkg::OP_MAC) begin
                        chain_next = round_ab;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_data;
                    m_match_next = res_match;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
            end
        endcase

        if (start) begin
            ab_next    = src_blk;
            sum_next   = 32'd0;
            cnt_next   = '0;
            state_next = (cmd.op == xmc_pkg::OP_RSVD) ? ST_DONE : ST_RUN;
            if (cmd.op == xmc_pkg::OP_CTR) begin
                ctr_next = {ctr_base[63:8], ctr_base[7:0] + 8'd1};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            chain_reg   <= 64'd0;
            ctr_reg     <= 64'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            chain_reg   <= chain_next;
            ctr_reg     <= ctr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ab_reg      <= ab_next;
        sum_reg     <= sum_next;
        m_data_reg  <= m_data_next;
        m_match_reg <= m_match_next;
        if (start) begin
            op_reg   <= cmd.op;
            data_reg <= cmd.data;
            mask_reg <= cmd.mask;
            last_reg <= cmd.last;
            exp_reg  <= cmd.exp_mic;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_data = m_data_reg;
    assign m_mic_match   = m_match_reg;

`ifndef SYNTHESIS
    a_sum_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && cnt_reg == '0) |-> sum_reg == 32'd0)
        else $error("round sum not cleared at start");
    a_ctr_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(start && cmd.op == xmc_pkg::OP_CTR) |=> $stable(ctr_reg))
        else $error("counter block moved outside a counter step");
    a_chain_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && cnt_reg != LAST_ROUND) |=> $stable(chain_reg))
        else $error("MAC chain changed mid-run");
    a_out_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result beat without finished block");
    a_done_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && !out_free) |=> (state_reg == ST_DONE && $stable(ab_reg)))
        else $error("finished block lost under stall");
`endif

endmodule

// ===== tb/xtea_mac_ctr_engine_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xtea_mac_ctr_engine_tb
// Self-checking bench for the XTEA encrypt / CBC-MAC / counter mode engine.
// Blocks are queued by the stimulus process and driven onto the s_ channel.
// Each accepted beat is run through a local XTEA model that tracks the MAC
// chain, the counter block and the key. Results on the m_ channel are compared
// in order against the model. Key registers are rewritten between phases
// while the engine is drained. Both channels stall at random, with one long
// output back-pressure stretch.
// ---------------------------------------------------------------------------
module xtea_mac_ctr_engine_tb;

    localparam int unsigned MIC_LEN      = xmc_pkg::MIC_BYTES_DEF;
    localparam int unsigned PHASE_BLOCKS = 300;
    localparam int unsigned NUM_PHASES   = 6;
    localparam int unsigned HOLD_AT      = 150;
    localparam int unsigned HOLD_CYCLES  = 500;
    localparam int unsigned STALL_LIMIT  = 4000;

    typedef struct {
        xmc_pkg::op_t op;
        logic [63:0]  data;
        logic [3:0]   vbytes;
        logic         first;
        logic         last;
        logic [63:0]  cstart;
        logic [31:0]  mic;
    } blk_item_t;

    typedef struct {
        logic [63:0] data;
        logic        mic_ok;
    } blk_result_t;

    typedef enum int {
        MIC_AS_GIVEN,
        MIC_RIGHT,
        MIC_NEAR
    } mic_pick_t;

    logic                          aclk            = 1'b0;
    logic                          aresetn         = 1'b0;
    logic                          cfg_valid       = 1'b0;
    logic                          cfg_ready;
    logic [xmc_pkg::CFG_IDX_W-1:0] cfg_index       = '0;
    logic [63:0]                   cfg_data        = '0;
    logic                          s_valid         = 1'b0;
    logic                          s_ready;
    logic [1:0]                    s_opcode        = '0;
    logic [63:0]                   s_block_data    = '0;
    logic [3:0]                    s_valid_bytes   = '0;
    logic                          s_first         = 1'b0;
    logic                          s_last          = 1'b0;
    logic [63:0]                   s_counter_start = '0;
    logic [31:0]                   s_expected_mic  = '0;
    logic                          m_valid;
    logic                          m_ready         = 1'b0;
    logic [63:0]                   m_result_data;
    logic                          m_mic_match;

    blk_item_t   pending_blocks[$];
    blk_result_t expected_results[$];
    blk_item_t   cur_blk;
    blk_result_t want;

    // key as written into the engine
    logic [63:0] key_hi = '0;
    logic [63:0] key_lo = '0;
    // engine state as seen at accepted beats
    logic [63:0] model_chain = '0;
    logic [63:0] model_ctr   = '0;
    // chain as seen while building stimulus, used to form matching MICs
    logic [63:0] stim_chain  = '0;

    int unsigned rx_count    = 0;
    int unsigned hold_left   = 0;
    bit          hold_done   = 1'b0;
    bit          quiet       = 1'b0;
    // follows s_valid already within the edge that changes it
    bit          drv_loaded  = 1'b0;
    int unsigned stall_count = 0;
    int unsigned fail_count  = 0;

    xtea_mac_ctr_engine #(
        .MIC_BYTES(MIC_LEN)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_block_data   (s_block_data),
        .s_valid_bytes  (s_valid_bytes),
        .s_first        (s_first),
        .s_last         (s_last),
        .s_counter_start(s_counter_start),
        .s_expected_mic (s_expected_mic),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_data  (m_result_data),
        .m_mic_match    (m_mic_match)
    );

    always #5 aclk = ~aclk;

    function automatic logic [63:0] xtea_encipher(logic [63:0] blk, logic [63:0] khi,
                                                   logic [63:0] klo);
        logic [31:0] kw [0:3];
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] sum;
        kw[0] = khi[63:32];
        kw[1] = khi[31:0];
        kw[2] = klo[63:32];
        kw[3] = klo[31:0];
        y     = blk[63:32];
        z     = blk[31:0];
        sum   = '0;
        for (int r = 0; r < xmc_pkg::NUM_ROUNDS; r++) begin
            y   = y + ((((z << 4) ^ (z >> 5)) + z) ^ (sum + kw[sum[1:0]]));
            sum = sum + xmc_pkg::ROUND_DELTA;
            z   = z + ((((y << 4) ^ (y >> 5)) + y) ^ (sum + kw[sum[12:11]]));
        end
        return {y, z};
    endfunction

    function automatic logic [63:0] byte_mask(logic [3:0] n);
        if (n == 0) begin
            return '0;
        end
        if (n >= 8) begin
            return '1;
        end
        return ~64'd0 << (64 - 8 * n);
    endfunction

    function automatic logic [31:0] chain_mic(logic [63:0] chain);
        logic [63:0] lead;
        lead = chain >> (64 - 8 * MIC_LEN);
        return lead[31:0];
    endfunction

    // expected engine output for one accepted beat; advances the model state
    task automatic compute_engine_result(input blk_item_t it);
        blk_result_t r;
        logic [63:0] lead;
        r.data   = '0;
        r.mic_ok = 1'b0;
        case (it.op)
            xmc_pkg::OP_ENCRYPT: begin
                r.data = xtea_encipher(it.data, key_hi, key_lo);
            end
            xmc_pkg::OP_MAC: begin
                if (it.first) begin
                    model_chain = '0;
                end
                model_chain = xtea_encipher(model_chain ^ (it.data & byte_mask(it.vbytes)),
                                            key_hi, key_lo);
                r.data = model_chain;
                if (it.last) begin
                    lead     = model_chain >> (64 - 8 * MIC_LEN);
                    r.mic_ok = (lead == {32'd0, it.mic});
                end
            end
            xmc_pkg::OP_CTR: begin
                if (it.first) begin
                    model_ctr = it.cstart;
                end
                r.data = (it.data ^ xtea_encipher(model_ctr, key_hi, key_lo))
                         & byte_mask(it.vbytes);
                model_ctr[7:0] = model_ctr[7:0] + 8'd1;
            end
            default: begin
            end
        endcase
        expected_results.push_back(r);
    endtask

    function automatic blk_item_t mk_blk(xmc_pkg::op_t op, logic [63:0] data,
                                         logic [3:0] vb, logic first, logic last,
                                         logic [63:0] cstart, logic [31:0] mic);
        blk_item_t it;
        it.op     = op;
        it.data   = data;
        it.vbytes = vb;
        it.first  = first;
        it.last   = last;
        it.cstart = cstart;
        it.mic    = mic;
        return it;
    endfunction

    function automatic blk_item_t rand_blk(xmc_pkg::op_t op);
        return mk_blk(op, {$urandom, $urandom}, 4'($urandom_range(15)),
                      1'($urandom_range(1)), 1'($urandom_range(1)),
                      {$urandom, $urandom}, $urandom);
    endfunction

    function automatic logic [3:0] pick_vb();
        if ($urandom_range(99) < 15) begin
            return 4'($urandom_range(15));
        end
        return 4'($urandom_range(8, 1));
    endfunction

    function automatic mic_pick_t pick_mic();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55) begin
            return MIC_RIGHT;
        end
        if (r < 75) begin
            return MIC_NEAR;
        end
        return MIC_AS_GIVEN;
    endfunction

    task automatic queue_block(input blk_item_t it, input mic_pick_t how);
        if (it.op == xmc_pkg::OP_MAC) begin
            if (it.first) begin
                stim_chain = '0;
            end
            stim_chain = xtea_encipher(stim_chain ^ (it.data & byte_mask(it.vbytes)),
                                       key_hi, key_lo);
            if (how == MIC_RIGHT) begin
                it.mic = chain_mic(stim_chain);
            end else if (how == MIC_NEAR) begin
                it.mic = chain_mic(stim_chain) ^ (32'd1 << $urandom_range(31));
            end
        end
        pending_blocks.push_back(it);
    endtask

    task automatic fill_phase(input int unsigned n_blocks);
        int unsigned made;
        int unsigned len;
        int unsigned kind;
        blk_item_t   it;
        made = 0;
        while (made < n_blocks) begin
            kind = $urandom_range(99);
            if (kind < 40) begin
                len = $urandom_range(6, 1);
                for (int j = 0; j < len; j++) begin
                    it        = rand_blk(xmc_pkg::OP_MAC);
                    it.first  = (j == 0) ? ($urandom_range(9) != 0) : 1'b0;
                    it.last   = (j == len - 1);
                    it.vbytes = (it.last || $urandom_range(9) == 0) ? pick_vb() : 4'd8;
                    queue_block(it, it.last ? pick_mic() : MIC_AS_GIVEN);
                end
            end else if (kind < 75) begin
                len = $urandom_range(8, 1);
                for (int j = 0; j < len; j++) begin
                    it        = rand_blk(xmc_pkg::OP_CTR);
                    it.first  = (j == 0) ? ($urandom_range(9) != 0) : 1'b0;
                    it.vbytes = (j == len - 1) ? pick_vb() : 4'd8;
                    if ($urandom_range(99) < 30) begin
                        it.cstart[7:0] = 8'($urandom_range(255, 248));
                    end
                    queue_block(it, MIC_AS_GIVEN);
                end
            end else if (kind < 88) begin
                len = 1;
                queue_block(rand_blk(xmc_pkg::OP_ENCRYPT), MIC_AS_GIVEN);
            end else begin
                len = 1;
                queue_block(rand_blk(xmc_pkg::op_t'($urandom_range(3))), MIC_AS_GIVEN);
            end
            made += len;
        end
    endtask

    task automatic write_key(input xmc_pkg::cfg_idx_t idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == xmc_pkg::CFG_KEY_UPPER) begin
            key_hi = val;
        end else begin
            key_lo = val;
        end
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (pending_blocks.size() != 0 || drv_loaded || expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                compute_engine_result(cur_blk);
            end
            if (!s_valid || s_ready) begin
                if (pending_blocks.size() != 0 && (quiet || $urandom_range(99) >= 24)) begin
                    cur_blk = pending_blocks.pop_front();
                    drv_loaded = 1'b1;
                    s_valid         <= 1'b1;
                    s_opcode        <= cur_blk.op;
                    s_block_data    <= cur_blk.data;
                    s_valid_bytes   <= cur_blk.vbytes;
                    s_first         <= cur_blk.first;
                    s_last          <= cur_blk.last;
                    s_counter_start <= cur_blk.cstart;
                    s_expected_mic  <= cur_blk.mic;
                end else begin
                    drv_loaded = 1'b0;
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result back-pressure, with one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && rx_count == HOLD_AT) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_ready <= quiet || ($urandom_range(99) >= 24);
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            rx_count <= rx_count + 1;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result beat, got data %h mic_match %b",
                         $time, m_result_data, m_mic_match);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_result_data !== want.data) begin
                    $display("%0t: result_data mismatch, expected %h, got %h",
                             $time, want.data, m_result_data);
                    fail_count++;
                end
                if (m_mic_match !== want.mic_ok) begin
                    $display("%0t: mic_match mismatch, expected %b, got %b",
                             $time, want.mic_ok, m_mic_match);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on handshake progress
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("%0t: no handshake progress for %0d cycles", $time, stall_count);
            $display("FAIL xtea_mac_ctr_engine");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    initial begin
        logic [63:0] keys_upper [1:NUM_PHASES];
        logic [63:0] keys_lower [1:NUM_PHASES];
        keys_upper[1] = '1;                    keys_lower[1] = '1;
        keys_upper[2] = {$urandom, $urandom};  keys_lower[2] = {$urandom, $urandom};
        keys_upper[3] = '0;                    keys_lower[3] = '0;
        keys_upper[4] = {$urandom, $urandom};  keys_lower[4] = {$urandom, $urandom};
        keys_upper[5] = '1;                    keys_lower[5] = '0;
        keys_upper[6] = '0;                    keys_lower[6] = {$urandom, $urandom};

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed blocks under the all-zero reset key
        queue_block(mk_blk(xmc_pkg::OP_ENCRYPT, '0, 4'd8, 1'b0, 1'b0, '0, '0),
                    MIC_AS_GIVEN);
        queue_block(mk_blk(xmc_pkg::OP_ENCRYPT, '1, 4'd15, 1'b1, 1'b1, '1, '1),
                    MIC_AS_GIVEN);
        queue_block(mk_blk(xmc_pkg::OP_RSVD, '1, 4'd8, 1'b1, 1'b1, '1, '1), MIC_AS_GIVEN);
        // counter step before any counter load
        queue_block(mk_blk(xmc_pkg::OP_CTR, '1, 4'd8, 1'b0, 1'b0, '1, '0), MIC_AS_GIVEN);
        queue_block(mk_blk(xmc_pkg::OP_CTR, 64'h0123_4567_89ab_cdef, 4'd8, 1'b1, 1'b0,
                           64'h0000_0000_0000_00fe, '0), MIC_AS_GIVEN);
        queue_block(mk_blk(xmc_pkg::OP_CTR, '1, 4'd8, 1'b0, 1'b0, '0, '0), MIC_AS_GIVEN);
        queue_block(mk_blk(xmc_pkg::OP_CTR, '1, 4'd8, 1'b0, 1'b0, '0, '0), MIC_AS_GIVEN);
        queue_block(mk_blk(xmc_pkg::OP_CTR, '1, 4'd0, 1'b0, 1'b0, '0, '0), MIC_AS_GIVEN);
        queue_block(mk_blk(xmc_pkg::OP_CTR, '1, 4'd15, 1'b0, 1'b0, '0, '0), MIC_AS_GIVEN);
        queue_block(mk_blk(xmc_pkg::OP_CTR, '1, 4'd3, 1'b0, 1'b1, '0, '0), MIC_AS_GIVEN);
        queue_block(mk_blk(xmc_pkg::OP_MAC, '1, 4'd8, 1'b1, 1'b0, '0, '0), MIC_AS_GIVEN);
        queue_block(mk_blk(xmc_pkg::OP_MAC, 64'hdead_beef_cafe_f00d, 4'd0, 1'b0, 1'b0,
                           '0, '0), MIC_AS_GIVEN);
        queue_block(mk_blk(xmc_pkg::OP_MAC, 64'h1122_3344_5566_7788, 4'd12, 1'b0, 1'b1,
                           '0, '0), MIC_RIGHT);
        // chain carries on after a last block
        queue_block(mk_blk(xmc_pkg::OP_MAC, 64'h8877_6655_4433_2211, 4'd5, 1'b0, 1'b1,
                           '0, '0), MIC_NEAR);
        queue_block(mk_blk(xmc_pkg::OP_RSVD, '1, 4'd8, 1'b1, 1'b1, '1, '1), MIC_AS_GIVEN);
        queue_block(mk_blk(xmc_pkg::OP_ENCRYPT, {$urandom, $urandom}, 4'd0, 1'b0, 1'b0,
                           '0, '0), MIC_AS_GIVEN);
        queue_block(mk_blk(xmc_pkg::OP_MAC, '1, 4'd1, 1'b0, 1'b1, '0, '0), MIC_RIGHT);
        queue_block(mk_blk(xmc_pkg::OP_MAC, '0, 4'd8, 1'b1, 1'b1, '0, '0), MIC_RIGHT);
        queue_block(mk_blk(xmc_pkg::OP_MAC, '1, 4'd8, 1'b1, 1'b1, '0, '1), MIC_AS_GIVEN);
        queue_block(mk_blk(xmc_pkg::OP_CTR, '0, 4'd1, 1'b1, 1'b0, '1, '0), MIC_AS_GIVEN);
        queue_block(mk_blk(xmc_pkg::OP_CTR, '0, 4'd8, 1'b0, 1'b0, '0, '0), MIC_AS_GIVEN);
        wait_drained();

        for (int p = 1; p <= NUM_PHASES; p++) begin
            write_key(xmc_pkg::CFG_KEY_UPPER, keys_upper[p]);
            write_key(xmc_pkg::CFG_KEY_LOWER, keys_lower[p]);
            quiet = (p == 3);
            fill_phase(PHASE_BLOCKS);
            wait_drained();
        end
        quiet = 1'b0;

        repeat (100) @(posedge aclk);
        if (expected_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_results.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("PASS xtea_mac_ctr_engine");
        end else begin
            $display("FAIL xtea_mac_ctr_engine");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/xmc_pkg.sv
hw/rtl/xmc_front.sv
hw/rtl/xmc_back.sv
hw/rtl/xtea_mac_ctr_engine.sv
tb/xtea_mac_ctr_engine_tb.sv
